[sv/pas_pkg.sv]
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types and constants for the PID arctangent attitude steering block.
// ----------------------------------------------------------------------------
package pas_pkg;

  // angles in 1/256 degree
  localparam logic [16:0] TURN    = 17'd92160;
  localparam logic [16:0] DEG_1   = 17'd256;
  localparam logic [16:0] DEG_90  = 17'd23040;
  localparam logic [16:0] DEG_180 = 17'd46080;
  localparam logic [16:0] DEG_270 = 17'd69120;
  localparam logic [16:0] DEG_359 = 17'd91904;

  // thruster codes
  localparam logic [1:0] THR_MAIN  = 2'd0;
  localparam logic [1:0] THR_LEFT  = 2'd1;
  localparam logic [1:0] THR_RIGHT = 2'd2;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_PLATFORM_X,
    REG_GAIN_P,
    REG_GAIN_I,
    REG_GAIN_D,
    REG_INVERSE_STRETCH,
    REG_OFFSET_LIMIT,
    REG_THRUSTER_OK
  } cfg_reg_t;

  // datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE,
    OP_MAG,
    OP_DTERM,
    OP_ILO,
    OP_IHI,
    OP_ISUM,
    OP_USUM,
    OP_UMAG,
    OP_YLO,
    OP_YHI,
    OP_YSUM,
    OP_NORM,
    OP_ROT,
    OP_LIM,
    OP_WRAP,
    OP_CORR
  } op_t;

  typedef struct packed {
    logic load;
    logic publish;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic norm_done;
    logic rot_last;
    logic out_free;
  } status_t;

  // arctangent of 2^-i, quarter turn = 2^30
  function automatic logic [29:0] atan_entry(input logic [4:0] i);
    logic [29:0] r;
    case (i)
      5'd0:  r = 30'd536870912;
      5'd1:  r = 30'd316933406;
      5'd2:  r = 30'd167458907;
      5'd3:  r = 30'd85004756;
      5'd4:  r = 30'd42667331;
      5'd5:  r = 30'd21354465;
      5'd6:  r = 30'd10679838;
      5'd7:  r = 30'd5340245;
      5'd8:  r = 30'd2670163;
      5'd9:  r = 30'd1335087;
      5'd10: r = 30'd667544;
      5'd11: r = 30'd333772;
      5'd12: r = 30'd166886;
      5'd13: r = 30'd83443;
      5'd14: r = 30'd41722;
      5'd15: r = 30'd20861;
      5'd16: r = 30'd10430;
      5'd17: r = 30'd5215;
      5'd18: r = 30'd2608;
      5'd19: r = 30'd1304;
      5'd20: r = 30'd652;
      5'd21: r = 30'd326;
      5'd22: r = 30'd163;
      5'd23: r = 30'd81;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

[sv/pas_ctrl.sv]
// ----------------------------------------------------------------------------
// pas_ctrl
// Sequencer: steps the datapath through one control tick per request.
// ----------------------------------------------------------------------------
module pas_ctrl import pas_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_MAG, S_DTERM, S_ILO, S_IHI, S_ISUM, S_USUM, S_UMAG,
    S_YLO, S_YHI, S_YSUM, S_NORM, S_ROT, S_LIM, S_WRAP, S_CORR, S_DONE
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE:  if (in_valid) state <= S_MAG;
        S_MAG:   state <= S_DTERM;
        S_DTERM: state <= S_ILO;
        S_ILO:   state <= S_IHI;
        S_IHI:   state <= S_ISUM;
        S_ISUM:  state <= S_USUM;
        S_USUM:  state <= S_UMAG;
        S_UMAG:  state <= S_YLO;
        S_YLO:   state <= S_YHI;
        S_YHI:   state <= S_YSUM;
        S_YSUM:  state <= S_NORM;
        S_NORM:  if (status.norm_done) state <= S_ROT;
        S_ROT:   if (status.rot_last) state <= S_LIM;
        S_LIM:   state <= S_WRAP;
        S_WRAP:  state <= S_CORR;
        S_CORR:  state <= S_DONE;
        S_DONE:  if (status.out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready = (state == S_IDLE);

  // command decode
  always_comb begin
    cmd.load    = (state == S_IDLE) && in_valid;
    cmd.publish = (state == S_DONE) && status.out_free;
    case (state)
      S_MAG:   cmd.op = OP_MAG;
      S_DTERM: cmd.op = OP_DTERM;
      S_ILO:   cmd.op = OP_ILO;
      S_IHI:   cmd.op = OP_IHI;
      S_ISUM:  cmd.op = OP_ISUM;
      S_USUM:  cmd.op = OP_USUM;
      S_UMAG:  cmd.op = OP_UMAG;
      S_YLO:   cmd.op = OP_YLO;
      S_YHI:   cmd.op = OP_YHI;
      S_YSUM:  cmd.op = OP_YSUM;
      S_NORM:  cmd.op = OP_NORM;
      S_ROT:   cmd.op = OP_ROT;
      S_LIM:   cmd.op = OP_LIM;
      S_WRAP:  cmd.op = OP_WRAP;
      S_CORR:  cmd.op = OP_CORR;
      default: cmd.op = OP_NONE;
    endcase
  end

endmodule

[sv/pas_dp.sv]
// ----------------------------------------------------------------------------
// pas_dp
// Datapath: configuration, PID terms, CORDIC arctangent, rotation rule and
// the output register.
// ----------------------------------------------------------------------------
module pas_dp import pas_pkg::*; #(
  parameter int SUM_WIDTH    = 40,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data,
  input  logic [34:0] in_data,
  input  cmd_t        cmd,
  output status_t     status,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [36:0] out_data
);

  localparam int SW    = SUM_WIDTH;
  localparam int STEPS = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
  localparam int MW    = (SW > 49) ? SW : 49;
  localparam logic [MW-1:0] I_LIM_W = MW'(1) << 48;

  // configuration registers
  logic [17:0] platform_x;
  logic [15:0] gain_p, gain_i, gain_d, inv_st;
  logic [14:0] off_lim;
  logic [2:0]  thr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      platform_x <= 18'd0;
      gain_p     <= 16'd256;
      gain_i     <= 16'd0;
      gain_d     <= 16'd640;
      inv_st     <= 16'd655;
      off_lim    <= 15'd3840;
      thr_ok     <= 3'd7;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_PLATFORM_X:      platform_x <= cfg_data;
        REG_GAIN_P:          gain_p     <= cfg_data[15:0];
        REG_GAIN_I:          gain_i     <= cfg_data[15:0];
        REG_GAIN_D:          gain_d     <= cfg_data[15:0];
        REG_INVERSE_STRETCH: inv_st     <= cfg_data[15:0];
        REG_OFFSET_LIMIT:    off_lim    <= cfg_data[14:0];
        REG_THRUSTER_OK:     thr_ok     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // persistent and working registers
  logic signed [SW-1:0] error_sum;
  logic signed [18:0]   prev_err;
  logic                 prev_valid;
  logic signed [18:0]   e;
  logic signed [19:0]   d;
  logic [16:0]          att;
  logic                 sat, sum_neg, ibig, u_neg;
  logic [48:0]          smag49;
  logic signed [35:0]   pterm;
  logic signed [36:0]   dterm;
  logic [39:0]          ilo;
  logic [40:0]          ihi;
  logic signed [49:0]   iterm;
  logic signed [50:0]   u;
  logic [47:0]          umag;
  logic [39:0]          ylo, yhi;
  logic [32:0]          xm;
  logic [63:0]          ym;
  logic signed [33:0]   cx, cy, cz;
  logic [4:0]           step;
  logic [14:0]          offm;
  logic signed [15:0]   off;
  logic [1:0]           choice;
  logic [16:0]          target, attw;
  logic                 r_rot;
  logic signed [16:0]   r_amount;

  // load-time arithmetic
  logic signed [18:0] e_in;
  logic signed [SW:0] sum_ext;
  logic signed [19:0] d_in;
  assign e_in    = signed'({1'b0, platform_x} - {1'b0, in_data[17:0]});
  assign sum_ext = {error_sum[SW-1], error_sum} + {{(SW-18){e_in[18]}}, e_in};
  assign d_in    = prev_valid ? ({e_in[18], e_in} - {prev_err[18], prev_err}) : 20'sd0;

  // error-sum magnitude
  logic [SW-1:0] smag_w;
  logic [MW-1:0] smag_x;
  assign smag_w = error_sum[SW-1] ? (~error_sum + 1'b1) : error_sum;
  assign smag_x = MW'(smag_w);

  // integral term clamp
  logic [65:0]        iprod;
  logic [48:0]        imag_c;
  logic signed [49:0] im_s;
  always_comb begin
    iprod = {1'b0, ihi, 24'd0} + 66'(ilo);
    if (gain_i == 16'd0) imag_c = 49'd0;
    else if (ibig || iprod > 66'(49'h1_0000_0000_0000)) imag_c = 49'h1_0000_0000_0000;
    else imag_c = iprod[48:0];
    im_s = signed'({1'b0, imag_c});
  end

  // control magnitude clamp
  logic [50:0] ua;
  assign ua = u[50] ? 51'(-u) : 51'(u);

  // normalisation
  logic need, big7;
  assign need = (xm[32:30] != 3'd0) || (ym[63:30] != 34'd0);
  assign big7 = (ym[63:37] != 27'd0);

  // cordic step
  logic signed [33:0] shx, shy, at_s;
  assign shx  = cx >>> step;
  assign shy  = cy >>> step;
  assign at_s = signed'({4'd0, atan_entry(step)});

  // angle clamp and scaling
  logic [30:0] zc;
  logic [46:0] oprod;
  always_comb begin
    if (cz < 0) zc = 31'd0;
    else if (cz > 34'sh4000_0000) zc = 31'h4000_0000;
    else zc = cz[30:0];
    oprod = 47'(off_lim) * 47'(zc) + 47'h2000_0000;
  end

  // wrapping of target and attitude
  logic signed [15:0] off_s;
  logic signed [18:0] tsum;
  logic [16:0]        thr_ang;
  logic [1:0]         choice_w;
  logic [16:0]        target_w;
  always_comb begin
    off_s = u_neg ? -signed'({1'b0, offm}) : signed'({1'b0, offm});
    if (thr_ok[0]) begin
      choice_w = THR_MAIN;  thr_ang = 17'd0;
    end else if (thr_ok[1]) begin
      choice_w = THR_LEFT;  thr_ang = DEG_270;
    end else begin
      choice_w = THR_RIGHT; thr_ang = DEG_90;
    end
    tsum = 19'(off_s) + signed'({2'b0, thr_ang});
    if (tsum < 0) target_w = 17'(tsum + signed'({2'b0, TURN}));
    else if (tsum >= signed'({2'b0, TURN})) target_w = 17'(tsum - signed'({2'b0, TURN}));
    else target_w = tsum[16:0];
  end

  // rotation rule
  logic signed [17:0] cdiff;
  logic [16:0]        corr;
  always_comb begin
    cdiff = signed'({1'b0, attw}) - signed'({1'b0, target});
    corr  = (cdiff < 0) ? 17'(cdiff + signed'({1'b0, TURN})) : cdiff[16:0];
  end

  // persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum  <= '0;
      prev_err   <= '0;
      prev_valid <= 1'b0;
    end else if (cmd.load) begin
      if (sum_ext[SW] != sum_ext[SW-1])
        error_sum <= sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      else
        error_sum <= sum_ext[SW-1:0];
      prev_err   <= e_in;
      prev_valid <= 1'b1;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      e   <= e_in;
      d   <= d_in;
      att <= in_data[34:18];
      sat <= (sum_ext[SW] != sum_ext[SW-1]);
    end
    case (cmd.op)
      OP_MAG: begin
        pterm   <= signed'({1'b0, gain_p}) * e;
        sum_neg <= error_sum[SW-1];
        ibig    <= smag_x > I_LIM_W;
        smag49  <= smag_x[48:0];
      end
      OP_DTERM: dterm <= signed'({1'b0, gain_d}) * d;
      OP_ILO:   ilo   <= smag49[23:0] * gain_i;
      OP_IHI:   ihi   <= smag49[48:24] * gain_i;
      OP_ISUM:  iterm <= sum_neg ? -im_s : im_s;
      OP_USUM:  u     <= 51'(pterm) + 51'(dterm) + 51'(iterm);
      OP_UMAG: begin
        u_neg <= u[50];
        umag  <= (ua > 51'h8000_0000_0000) ? 48'h8000_0000_0000 : ua[47:0];
      end
      OP_YLO: ylo <= umag[23:0] * inv_st;
      OP_YHI: yhi <= umag[47:24] * inv_st;
      OP_YSUM: begin
        ym <= {yhi, 24'd0} + 64'(ylo);
        xm <= 33'h1_0000_0000;
      end
      OP_NORM: begin
        if (big7) begin
          xm <= xm >> 8;
          ym <= ym >> 8;
        end else if (need) begin
          xm <= xm >> 1;
          ym <= ym >> 1;
        end
        cx   <= signed'({1'b0, xm});
        cy   <= signed'({4'd0, ym[29:0]});
        cz   <= 34'sd0;
        step <= 5'd0;
      end
      OP_ROT: begin
        if (!cy[33]) begin
          cx <= cx + shy;
          cy <= cy - shx;
          cz <= cz + at_s;
        end else begin
          cx <= cx - shy;
          cy <= cy + shx;
          cz <= cz - at_s;
        end
        step <= step + 5'd1;
      end
      OP_LIM: offm <= oprod[44:30];
      OP_WRAP: begin
        off    <= off_s;
        choice <= choice_w;
        target <= target_w;
        attw   <= (att >= TURN) ? (att - TURN) : att;
      end
      OP_CORR: begin
        r_rot    <= (corr > DEG_1) && (corr < DEG_359);
        if ((corr > DEG_1) && (corr < DEG_359))
          r_amount <= (corr >= DEG_180) ? signed'(TURN - corr) : -signed'(corr);
        else
          r_amount <= 17'sd0;
      end
      default: ;
    endcase
  end

  // output register
  logic               o_rot, o_sat;
  logic signed [15:0] o_off;
  logic signed [16:0] o_amount;
  logic [1:0]         o_choice;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      o_off    <= off;
      o_rot    <= r_rot;
      o_amount <= r_amount;
      o_choice <= choice;
      o_sat    <= sat;
    end
  end

  assign out_data = {o_sat, o_choice, o_amount, o_rot, o_off};

  // status to the sequencer
  assign status.norm_done = !need;
  assign status.rot_last  = (step == 5'(STEPS - 1));
  assign status.out_free  = !out_valid || out_ready;

endmodule

[sv/pid_arctan_attitude_steer.sv]
// ----------------------------------------------------------------------------
// pid_arctan_attitude_steer
// PID on the platform position error with a CORDIC arctangent output limit,
// thruster selection and wrapped rotation command.
// ----------------------------------------------------------------------------
// One request is worked at a time. Between one accepted request and the next
// the sequencer steps through its fixed states, the normalisation steps that
// shift the arctangent argument below 2^30 (eight bits a cycle while it is at
// or above 2^37, then one bit a cycle) and CORDIC_STEPS iterations, at most
// 24, of the single shared CORDIC stage, and the result waits until the
// output register is free. The next request is taken as soon as the result
// has moved into that register. Configuration writes take effect at once and
// should only be made while no request is in progress.
module pid_arctan_attitude_steer import pas_pkg::*; #(
  parameter int SUM_WIDTH    = 40,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [17:0] measured_x, [34:18] attitude, [39:35] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] attitude_offset, [16] rotate_valid, [33:17] rotate_amount,
  // [35:34] thruster_choice, [36] integral_saturated, [39:37] zero
  output logic [39:0] m_axis_tdata
);

  cmd_t        cmd;
  status_t     status;
  logic [36:0] out_data;

  // sequencer
  pas_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  pas_dp #(
    .SUM_WIDTH    (SUM_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata[34:0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data)
  );

  assign m_axis_tdata = {3'd0, out_data};

endmodule

[sv/pas_checker.sv]
// ----------------------------------------------------------------------------
// pas_checker
// Port-level checks on the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module pas_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // a result waiting is held
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  // one request at a time: busy after accepting
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // no rotation means zero amount
  a_no_rot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[16] |-> m_axis_tdata[33:17] == 17'd0)
    else $error("rotation amount without rotation");

  // a rotation is never zero and the choice is a real thruster
  a_rot_amt: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (!m_axis_tdata[16] || m_axis_tdata[33:17] != 17'd0)
                      && m_axis_tdata[35:34] != 2'd3)
    else $error("bad rotation or thruster code");

endmodule

bind pid_arctan_attitude_steer pas_checker u_pas_checker (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for pid_arctan_attitude_steer: directed and random
// control ticks against a bit-true predictor kept in a scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pas_pkg::*;

  localparam int SUM_WIDTH    = 40;
  localparam int CORDIC_STEPS = 16;
  localparam longint TURN_L   = 92160;
  localparam longint LIMIT    = 3000000;

  typedef struct packed {
    logic               sat;
    logic [1:0]         choice;
    logic signed [16:0] amount;
    logic               rot;
    logic signed [15:0] offset;
  } steer_t;

  // steering predictor and store of expected commands
  class steer_board;
    logic [17:0] plat_x;
    logic [15:0] kp, ki, kd, inv_stretch;
    logic [14:0] off_lim;
    logic [2:0]  thr_ok;
    longint      err_sum, prev_err;
    bit          prev_ok;
    steer_t      pending[$];
    int          fails;

    function new();
      plat_x = 0; kp = 256; ki = 0; kd = 640; inv_stretch = 655;
      off_lim = 3840; thr_ok = 7; err_sum = 0; prev_err = 0; prev_ok = 0;
      fails = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [17:0] v);
      case (idx)
        REG_PLATFORM_X:      plat_x = v;
        REG_GAIN_P:          kp = v[15:0];
        REG_GAIN_I:          ki = v[15:0];
        REG_GAIN_D:          kd = v[15:0];
        REG_INVERSE_STRETCH: inv_stretch = v[15:0];
        REG_OFFSET_LIMIT:    off_lim = v[14:0];
        REG_THRUSTER_OK:     thr_ok = v[2:0];
        default: ;
      endcase
    endfunction

    function longint fshift(longint v, int s);
      return v >>> s;
    endfunction

    function longint wrap(longint v);
      longint r;
      r = v % TURN_L;
      if (r < 0) r += TURN_L;
      return r;
    endfunction

    function longint arctan_off(longint u);
      longint unsigned mag, xm, ym;
      longint x, y, z, nx, ny, o;
      mag = (u < 0) ? -u : u;
      if (mag > (64'd1 << 47)) mag = 64'd1 << 47;
      ym = mag * inv_stretch;
      xm = 64'd1 << 32;
      while (xm >= (64'd1 << 30) || ym >= (64'd1 << 30)) begin
        xm >>= 1;
        ym >>= 1;
      end
      x = xm; y = ym; z = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
        if (y >= 0) begin
          nx = x + fshift(y, i); ny = y - fshift(x, i); z += atan_entry(5'(i));
        end else begin
          nx = x - fshift(y, i); ny = y + fshift(x, i); z -= atan_entry(5'(i));
        end
        x = nx; y = ny;
      end
      if (z < 0) z = 0;
      if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
      o = (longint'(off_lim) * z + (64'sd1 << 29)) >>> 30;
      return (u < 0) ? -o : o;
    endfunction

    // work out the command for one accepted tick
    function void note_tick(logic [17:0] pos, logic [16:0] att);
      longint e, hi, lo, d, u, it, off, tgt, corr, ang;
      longint unsigned smag, imag;
      steer_t r;
      r = '0;
      hi = (64'sd1 <<< (SUM_WIDTH - 1)) - 1;
      lo = -hi - 1;
      e = longint'(plat_x) - longint'(pos);
      if (e > 0 && err_sum > hi - e) begin
        err_sum = hi; r.sat = 1;
      end else if (e < 0 && err_sum < lo - e) begin
        err_sum = lo; r.sat = 1;
      end else err_sum += e;
      d = prev_ok ? e - prev_err : 0;
      prev_err = e; prev_ok = 1;
      smag = (err_sum < 0) ? -err_sum : err_sum;
      if (ki == 0) imag = 0;
      else if (smag > (64'd1 << 48)) imag = 64'd1 << 48;
      else begin
        imag = smag * ki;
        if (imag > (64'd1 << 48)) imag = 64'd1 << 48;
      end
      it = (err_sum < 0) ? -longint'(imag) : longint'(imag);
      u = longint'(kp) * e + it + longint'(kd) * d;
      off = arctan_off(u);
      if (thr_ok[0]) begin
        r.choice = THR_MAIN; ang = 0;
      end else if (thr_ok[1]) begin
        r.choice = THR_LEFT; ang = DEG_270;
      end else begin
        r.choice = THR_RIGHT; ang = DEG_90;
      end
      tgt = wrap(off + ang);
      corr = wrap(wrap(att) - tgt);
      if (corr > DEG_1 && corr < DEG_359) begin
        r.rot = 1;
        r.amount = 17'((corr >= DEG_180) ? TURN_L - corr : -corr);
      end
      r.offset = 16'(off);
      pending.push_back(r);
    endfunction

    function void check_cmd(logic [39:0] data);
      steer_t got, exp_r;
      got = data[36:0];
      if (pending.size() == 0) begin
        $display("%0t unexpected command %h", $time, data);
        fails++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.offset !== exp_r.offset) begin
        $display("%0t offset exp %0d got %0d", $time, exp_r.offset, got.offset); fails++;
      end
      if (got.rot !== exp_r.rot) begin
        $display("%0t rotate_valid exp %0d got %0d", $time, exp_r.rot, got.rot); fails++;
      end
      if (got.amount !== exp_r.amount) begin
        $display("%0t amount exp %0d got %0d", $time, exp_r.amount, got.amount); fails++;
      end
      if (got.choice !== exp_r.choice) begin
        $display("%0t thruster exp %0d got %0d", $time, exp_r.choice, got.choice); fails++;
      end
      if (got.sat !== exp_r.sat) begin
        $display("%0t saturated exp %0d got %0d", $time, exp_r.sat, got.sat); fails++;
      end
      if (data[39:37] !== 3'b0) begin
        $display("%0t pad exp 0 got %b", $time, data[39:37]); fails++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [39:0] m_axis_tdata;
  steer_board  board;
  longint      cycles = 0;
  bit          rx_run = 1;

  always #1 clk = ~clk;

  pid_arctan_attitude_steer #(.SUM_WIDTH(SUM_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
  );

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[pid_arctan_attitude_steer] ERROR");
      $finish;
    end
  end

  // result side: random wait before each result, check on handshake
  initial begin
    int gap;
    board = new();
    @(posedge clk);
    while (rx_run) begin
      gap = $urandom_range(0, 6);
      m_axis_tready <= 0;
      repeat (gap) @(posedge clk);
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid && rx_run) @(posedge clk);
      if (m_axis_tvalid) board.check_cmd(m_axis_tdata);
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [17:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.write_reg(idx, v);
  endtask

  task automatic send_tick(logic [17:0] pos, logic [16:0] att, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {5'b0, att, pos};
    do @(posedge clk); while (!s_axis_tready);
    board.note_tick(pos, att);
  endtask

  // idle point for register writes
  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_phase(int n);
    logic [17:0] base;
    bit burst;
    base = board.plat_x;
    burst = $urandom_range(0, 3) == 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        send_tick(18'($urandom), 17'($urandom_range(0, 131071)), burst);
      else
        send_tick(18'(base + $urandom_range(0, 2047) - 1024),
                  17'($urandom_range(0, 92159)), burst);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: field extremes and special cases
    send_tick(0, 0, 0);
    send_tick(18'h3FFFF, 17'h1FFFF, 0);
    send_tick(0, 92159, 0);
    send_tick(18'h3FFFF, 92160, 0);
    send_tick(100, 256, 1);
    send_tick(0, 257, 1);
    send_tick(0, DEG_359, 0);
    send_tick(0, DEG_180, 0);
    drain();
    write_reg(REG_THRUSTER_OK, 3'b010);
    write_reg(REG_INVERSE_STRETCH, 0);
    write_reg(REG_OFFSET_LIMIT, 15'h7FFF);
    send_tick(5000, DEG_270, 0);
    send_tick(200000, 0, 0);
    drain();
    write_reg(REG_THRUSTER_OK, 3'b000);
    write_reg(REG_INVERSE_STRETCH, 16'hFFFF);
    write_reg(REG_GAIN_I, 16'hFFFF);
    write_reg(REG_PLATFORM_X, 18'h3FFFF);
    // build up the error sum with a large steady error
    for (int i = 0; i < 12; i++) send_tick(0, DEG_90, 0);
    drain();
    // random phases over several settings
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_PLATFORM_X, 18'((ph == 1) ? 18'h0 : $urandom));
      write_reg(REG_GAIN_P, 18'((ph == 2) ? 16'hFFFF : (ph == 3) ? 16'h0 : $urandom));
      write_reg(REG_GAIN_I, 18'((ph % 3 == 0) ? 16'h0 : $urandom_range(0, 65535)));
      write_reg(REG_GAIN_D, 18'((ph == 4) ? 16'hFFFF : $urandom));
      write_reg(REG_INVERSE_STRETCH, 18'((ph == 5) ? 1 : $urandom_range(0, 65535)));
      write_reg(REG_OFFSET_LIMIT, 18'((ph == 6) ? 0 : (ph == 7) ? 15'h7FFF
                : $urandom_range(0, 23040)));
      write_reg(REG_THRUSTER_OK, 18'($urandom_range(0, 7)));
      random_phase(112);
      drain();
    end
    repeat (100) @(posedge clk);
    rx_run = 0;
    @(posedge clk);
    if (board.fails == 0 && board.pending.size() == 0)
      $display("[pid_arctan_attitude_steer] OK");
    else
      $display("[pid_arctan_attitude_steer] ERROR");
    $finish;
  end
endmodule

[pid_arctan_attitude_steer.f]
sv/pas_pkg.sv
sv/pas_ctrl.sv
sv/pas_dp.sv
sv/pid_arctan_attitude_steer.sv
sv/pas_checker.sv
test/tb.sv
